[design/fir_pkg.sv]
package fir_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int COEF_W       = 16;
	localparam int ACC_W        = 32;
	localparam int DIGIT_W      = 4;
	localparam int NUM_DIGITS   = SAMPLE_W / DIGIT_W;
	localparam int DIGIT_IDX_W  = $clog2(NUM_DIGITS);
	localparam int PP_W         = COEF_W + DIGIT_W + 1;
	localparam int HALF_LEN     = 12;
	localparam int HALF_IDX_W   = $clog2(HALF_LEN);
	localparam int TAPS_DEFAULT = 23;

	localparam logic signed [COEF_W-1:0] HALF_COEF [HALF_LEN] = '{
		-16'sd115,  -16'sd815,  -16'sd1533, -16'sd1255,
		 16'sd337,   16'sd1592,  16'sd499,  -16'sd2137,
		-16'sd2367,  16'sd2580,  16'sd10031, 16'sd13636
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic                   load;
		logic                   rotate;
	} line_ctrl_t;

	typedef struct packed {
		logic                   clear_acc;
		logic                   active;
		logic [DIGIT_IDX_W-1:0] digit_idx;
		logic                   last_digit;
	} mac_ctrl_t;

	// symmetric table: tap k uses min(k, taps-1-k), clamped to the center entry
	function automatic logic signed [COEF_W-1:0] coef_for(input int unsigned k,
			input int unsigned taps);
		int unsigned           m;
		logic [HALF_IDX_W-1:0] idx;
		m = taps - 1 - k;
		if (k < m) begin
			m = k;
		end
		if (m > HALF_LEN - 1) begin
			m = HALF_LEN - 1;
		end
		idx = HALF_IDX_W'(m);
		return HALF_COEF[idx];
	endfunction

endpackage

[design/fir_delay_line.sv]
module fir_delay_line #(
	parameter int TAPS = fir_pkg::TAPS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fir_pkg::line_ctrl_t                  ctrl,
	input  logic signed [fir_pkg::SAMPLE_W-1:0]  sample,
	output logic signed [fir_pkg::SAMPLE_W-1:0]  tap_word
);

	// entry 0 is the newest sample; rotation walks the taps past entry 0
	logic signed [fir_pkg::SAMPLE_W-1:0] line_q [TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				line_q[i] <= '0;
			end
		end else if (ctrl.load) begin
			line_q[0] <= sample;
			for (int i = 1; i < TAPS; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end else if (ctrl.rotate) begin
			for (int i = 0; i < TAPS - 1; i++) begin
				line_q[i] <= line_q[i+1];
			end
			line_q[TAPS-1] <= line_q[0];
		end
	end

	assign tap_word = line_q[0];

endmodule

[design/fir_mac.sv]
module fir_mac (
	input  logic                                clk,
	input  fir_pkg::mac_ctrl_t                  ctrl,
	input  logic signed [fir_pkg::SAMPLE_W-1:0] tap_word,
	input  logic signed [fir_pkg::COEF_W-1:0]   coef,
	output logic signed [fir_pkg::ACC_W-1:0]    acc
);

	logic signed [fir_pkg::ACC_W-1:0]   prod_q;
	logic signed [fir_pkg::ACC_W-1:0]   acc_q;
	logic        [fir_pkg::DIGIT_W-1:0] digit;
	logic signed [fir_pkg::DIGIT_W:0]   digit_x;
	logic signed [fir_pkg::PP_W-1:0]    pp;
	logic signed [fir_pkg::ACC_W-1:0]   prod_shift;
	logic signed [fir_pkg::ACC_W-1:0]   prod_next;

	// digits taken most significant first; only the top digit is signed
	always_comb begin
		digit = tap_word[(fir_pkg::NUM_DIGITS - 1 - int'(ctrl.digit_idx)) * fir_pkg::DIGIT_W
			+: fir_pkg::DIGIT_W];
		if (ctrl.digit_idx == '0) begin
			digit_x = {digit[fir_pkg::DIGIT_W-1], digit};
		end else begin
			digit_x = {1'b0, digit};
		end
		pp         = fir_pkg::PP_W'(coef * digit_x);
		prod_shift = (ctrl.digit_idx == '0) ? '0 : (prod_q <<< fir_pkg::DIGIT_W);
		prod_next  = prod_shift + fir_pkg::ACC_W'(pp);
	end

	always_ff @(posedge clk) begin
		if (ctrl.active) begin
			prod_q <= prod_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear_acc) begin
			acc_q <= '0;
		end else if (ctrl.active && ctrl.last_digit) begin
			acc_q <= acc_q + prod_next;
		end
	end

	assign acc = acc_q;

endmodule

[design/fir_filter_23_tap.sv]
// In ST_RUN each sample is worked one 4-bit digit of one tap per cycle through a single
// 16x5 multiplier; then ST_HOLD loads the output register and ST_IDLE takes a new sample.
// A new sample is taken while the previous result waits; the load stalls until it leaves.
// Reset (arst_n low, asynchronous) clears the delay line to zero and empties the output.
module fir_filter_23_tap #(
	parameter int TAPS = fir_pkg::TAPS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic signed [fir_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                filtered_valid,
	input  logic                                filtered_ready,
	output logic signed [fir_pkg::SAMPLE_W-1:0] filtered_out
);

	localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;

	fir_pkg::state_t                     state_q;
	fir_pkg::state_t                     state_next;
	logic [TAP_W-1:0]                    tap_q;
	logic [fir_pkg::DIGIT_IDX_W-1:0]     digit_q;
	logic                                last_digit;
	logic                                last_tap;
	logic                                accept;
	logic                                out_load;
	logic                                out_valid_q;
	logic signed [fir_pkg::SAMPLE_W-1:0] out_q;
	fir_pkg::line_ctrl_t                 line_ctrl;
	fir_pkg::mac_ctrl_t                  mac_ctrl;
	logic signed [fir_pkg::SAMPLE_W-1:0] tap_word;
	logic signed [fir_pkg::COEF_W-1:0]   coef;
	logic signed [fir_pkg::ACC_W-1:0]    acc;

	assign last_digit = (digit_q == fir_pkg::DIGIT_IDX_W'(fir_pkg::NUM_DIGITS - 1));
	assign last_tap   = (tap_q == TAP_W'(TAPS - 1));
	assign accept     = sample_valid && sample_ready;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			fir_pkg::ST_IDLE: begin
				if (sample_valid) begin
					state_next = fir_pkg::ST_RUN;
				end
			end
			fir_pkg::ST_RUN: begin
				if (last_digit && last_tap) begin
					state_next = fir_pkg::ST_HOLD;
				end
			end
			fir_pkg::ST_HOLD: begin
				if (!out_valid_q || filtered_ready) begin
					state_next = fir_pkg::ST_IDLE;
				end
			end
			default: state_next = fir_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		sample_ready        = 1'b0;
		out_load            = 1'b0;
		line_ctrl.load      = 1'b0;
		line_ctrl.rotate    = 1'b0;
		mac_ctrl.clear_acc  = 1'b0;
		mac_ctrl.active     = 1'b0;
		mac_ctrl.digit_idx  = digit_q;
		mac_ctrl.last_digit = last_digit;
		unique case (state_q)
			fir_pkg::ST_IDLE: begin
				sample_ready       = 1'b1;
				line_ctrl.load     = sample_valid;
				mac_ctrl.clear_acc = sample_valid;
			end
			fir_pkg::ST_RUN: begin
				mac_ctrl.active  = 1'b1;
				line_ctrl.rotate = last_digit;
			end
			fir_pkg::ST_HOLD: begin
				out_load = !out_valid_q || filtered_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fir_pkg::ST_IDLE;
			tap_q   <= '0;
			digit_q <= '0;
		end else begin
			state_q <= state_next;
			if (accept) begin
				tap_q   <= '0;
				digit_q <= '0;
			end else if (state_q == fir_pkg::ST_RUN) begin
				digit_q <= digit_q + 1'b1;
				if (last_digit && !last_tap) begin
					tap_q <= tap_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (filtered_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= acc[fir_pkg::SAMPLE_W + 14:15];
		end
	end

	assign coef = fir_pkg::coef_for(int'(tap_q), TAPS);

	fir_delay_line #(
		.TAPS (TAPS)
	) u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (line_ctrl),
		.sample   (sample_in),
		.tap_word (tap_word)
	);

	fir_mac u_mac (
		.clk      (clk),
		.ctrl     (mac_ctrl),
		.tap_word (tap_word),
		.coef     (coef),
		.acc      (acc)
	);

	assign filtered_valid = out_valid_q;
	assign filtered_out   = out_q;

endmodule
